// ----- rtl/rmq_pkg.sv -----
// Package for the rotation matrix to quaternion block: payload types and case codes.
// Depends on nothing; used by the top level, the checker and the testbench.
`default_nettype none
package rmq_pkg;
  localparam int DW = 16;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [DW-1:0] right_x;
    logic signed [DW-1:0] right_y;
    logic signed [DW-1:0] right_z;
    logic signed [DW-1:0] up_x;
    logic signed [DW-1:0] up_y;
    logic signed [DW-1:0] up_z;
    logic signed [DW-1:0] fwd_x;
    logic signed [DW-1:0] fwd_y;
    logic signed [DW-1:0] fwd_z;
  } mat_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic [1:0]           case_taken;
  } quat_t;
endpackage
`default_nettype wire

// ----- rtl/rmq_sqrt.sv -----
// Pipelined integer square root, two result bits per stage, with a sideband.
// Depends on nothing outside this file.
`default_nettype none
module rmq_sqrt #(
  parameter int RW = 32,
  parameter int SW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [RW-1:0]     in_rad,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [RW/2-1:0]        out_root,
  output logic [SW-1:0]          out_side
);
  localparam int QW = RW / 2;
  localparam int NS = (QW + 1) / 2;

  logic [NS:0]     vld;
  logic [RW-1:0]   rem  [NS+1];
  logic [QW-1:0]   root [NS+1];
  logic [RW-1:0]   rad  [NS+1];
  logic [SW-1:0]   side [NS+1];

  always_comb begin
    rem[0]  = '0;
    root[0] = '0;
    rad[0]  = in_rad;
    side[0] = in_side;
    vld[0]  = in_valid;
  end

  // Each stage resolves two root bits from the top four radicand bits left.
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [RW+1:0] r1, r2, t1, t2;
    logic [QW-1:0] q1, q2;
    logic [RW-1:0] d1;
    always_comb begin
      r1 = {rem[s][RW-1:0], rad[s][RW-1 -: 2]};
      t1 = r1 - {root[s], 2'b01};
      if (!t1[RW+1]) begin
        r1 = t1;
        q1 = {root[s][QW-2:0], 1'b1};
      end else begin
        q1 = {root[s][QW-2:0], 1'b0};
      end
      d1 = rad[s] << 2;
      r2 = {r1[RW-1:0], d1[RW-1 -: 2]};
      t2 = r2 - {q1, 2'b01};
      if (!t2[RW+1]) begin
        r2 = t2;
        q2 = {q1[QW-2:0], 1'b1};
      end else begin
        q2 = {q1[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else     vld[s+1] <= vld[s];
      rem[s+1]  <= r2[RW-1:0];
      root[s+1] <= q2;
      rad[s+1]  <= rad[s] << 4;
      side[s+1] <= side[s];
    end
  end

  assign out_valid = vld[NS];
  assign out_root  = root[NS];
  assign out_side  = side[NS];
endmodule
`default_nettype wire

// ----- rtl/rmq_div.sv -----
// Pipelined restoring divider with saturation: trunc(n * 2^F / (2q)).
// Depends on nothing outside this file.
`default_nettype none
module rmq_div #(
  parameter int NW = 18,
  parameter int QW = 16,
  parameter int F  = 14,
  parameter int DW = 16
) (
  input  wire logic                 clk,
  input  wire logic signed [NW-1:0] num,
  input  wire logic [QW-1:0]        q,
  output logic signed [DW-1:0]      quo
);
  localparam int MW = NW + F;
  localparam int DV = QW + 1;
  localparam int NS = (MW + 3) / 4;
  localparam int LW = NS * 4;
  localparam int PW = LW + 1;

  logic [LW-1:0] dvd [NS+1];
  logic [LW-1:0] acc [NS+1];
  logic [DV:0]   rmd [NS+1];
  logic [DV-1:0] dvs [NS+1];
  logic          neg [NS+1];
  logic          zq  [NS+1];
  logic          zn  [NS+1];

  // Pad the dividend on top so the stage count covers every bit exactly.
  always_comb begin
    dvd[0] = LW'({(num[NW-1] ? -num : num), {F{1'b0}}});
    acc[0] = '0;
    rmd[0] = '0;
    dvs[0] = {q, 1'b0};
    neg[0] = num[NW-1];
    zq[0]  = (q == '0);
    zn[0]  = (num == '0);
  end

  // Four quotient bits per stage.
  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DV:0]   r;
    logic [LW-1:0] a, d;
    always_comb begin
      r = rmd[s];
      a = acc[s];
      d = dvd[s];
      for (int k = 0; k < 4; k++) begin
        r = {r[DV-1:0], d[LW-1]};
        d = d << 1;
        a = a << 1;
        if (r >= {1'b0, dvs[s]}) begin
          r = r - {1'b0, dvs[s]};
          a[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      rmd[s+1] <= r;
      acc[s+1] <= a;
      dvd[s+1] <= d;
      dvs[s+1] <= dvs[s];
      neg[s+1] <= neg[s];
      zq[s+1]  <= zq[s];
      zn[s+1]  <= zn[s];
    end
  end

  // Apply sign and saturate to the signed output range.
  logic [PW-1:0] mag;
  localparam logic [PW-1:0] SMAXV = PW'((64'd1 << (DW - 1)) - 1);
  always_comb begin
    mag = {1'b0, acc[NS]};
    if (zn[NS]) begin
      quo = '0;
    end else if (zq[NS]) begin
      quo = neg[NS] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (neg[NS]) begin
      if (mag > SMAXV + PW'(1)) quo = {1'b1, {(DW-1){1'b0}}};
      else                      quo = DW'(-mag);
    end else begin
      if (mag > SMAXV) quo = {1'b0, {(DW-1){1'b1}}};
      else             quo = DW'(mag);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Channel  Ports                  Handshake
// input    start, busy, mat       transfer when start && !busy
// result   done, quat             one-cycle strobe, no back pressure
//
// One item per cycle; busy stays low since the pipeline never stalls.
// At the default widths: 1 setup stage, 8 root stages, 9 divider stages
// and 1 output register.
// Reset (rst, synchronous) clears only the valid bits.
// Top level; depends on rmq_pkg, rmq_sqrt, rmq_div.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS  = 14
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire rmq_pkg::mat_t mat,
  output logic               done,
  output rmq_pkg::quat_t     quat
);
  import rmq_pkg::*;

  localparam int DATA_WIDTH = DW;
  localparam int NW = (DATA_WIDTH > FRAC_BITS ? DATA_WIDTH : FRAC_BITS + 1) + 3;
  localparam int RW = 4 * ((NW + FRAC_BITS + 2) / 4);
  localparam int QW = RW / 2;
  localparam int SW = 2 + 3 * NW;
  localparam int DSTG = (NW + FRAC_BITS + 3) / 4;

  assign busy = 1'b0;

  // Setup: pick branch, radicand and off-diagonal sums and differences.
  logic signed [NW-1:0] rx, ry, rz, ux, uy, uz, fx, fy, fz, one, tr, r;
  logic signed [NW-1:0] n0, n1, n2;
  case_t c;
  always_comb begin
    rx = NW'(mat.right_x); ry = NW'(mat.right_y); rz = NW'(mat.right_z);
    ux = NW'(mat.up_x);    uy = NW'(mat.up_y);    uz = NW'(mat.up_z);
    fx = NW'(mat.fwd_x);   fy = NW'(mat.fwd_y);   fz = NW'(mat.fwd_z);
    one = NW'(1) <<< FRAC_BITS;
    tr = rx + uy + fz;
    if (tr > one) begin
      c = CASE_TRACE; r = tr + one;
      n0 = uz - fy; n1 = fx - rz; n2 = ry - ux;
    end else if (rx > uy && rx > fz) begin
      c = CASE_X; r = one + rx - uy - fz;
      n0 = uz - fy; n1 = ry + ux; n2 = rz + fx;
    end else if (uy > fz) begin
      c = CASE_Y; r = one + uy - rx - fz;
      n0 = fx - rz; n1 = ry + ux; n2 = uz + fy;
    end else begin
      c = CASE_Z; r = one + fz - rx - uy;
      n0 = ry - ux; n1 = rz + fx; n2 = uz + fy;
    end
  end

  logic          s1_vld;
  logic [RW-1:0] s1_rad;
  logic [SW-1:0] s1_side;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start;
    s1_rad  <= r[NW-1] ? '0 : RW'({r[NW-2:0], {FRAC_BITS{1'b0}}});
    s1_side <= {c, n0, n1, n2};
  end

  logic          s2_vld;
  logic [QW-1:0] s2_q;
  logic [SW-1:0] s2_side;
  rmq_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
    .clk, .rst, .in_valid(s1_vld), .in_rad(s1_rad), .in_side(s1_side),
    .out_valid(s2_vld), .out_root(s2_q), .out_side(s2_side)
  );

  logic signed [DATA_WIDTH-1:0] d0, d1, d2;
  rmq_div #(.NW(NW), .QW(QW), .F(FRAC_BITS), .DW(DATA_WIDTH)) u_d0 (
    .clk, .num(s2_side[3*NW-1:2*NW]), .q(s2_q), .quo(d0));
  rmq_div #(.NW(NW), .QW(QW), .F(FRAC_BITS), .DW(DATA_WIDTH)) u_d1 (
    .clk, .num(s2_side[2*NW-1:NW]), .q(s2_q), .quo(d1));
  rmq_div #(.NW(NW), .QW(QW), .F(FRAC_BITS), .DW(DATA_WIDTH)) u_d2 (
    .clk, .num(s2_side[NW-1:0]), .q(s2_q), .quo(d2));

  // Delay line for valid, case and half root alongside the dividers.
  logic [DSTG:0]           dv;
  logic [1:0]              dc [DSTG+1];
  logic [DATA_WIDTH-1:0]   dh [DSTG+1];
  logic [QW-1:0]           hq;
  always_comb begin
    hq = s2_q >> 1;
    dv[0] = s2_vld;
    dc[0] = s2_side[SW-1 -: 2];
    if (QW > DATA_WIDTH - 1 && (hq >> (DATA_WIDTH - 1)) != '0)
      dh[0] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    else
      dh[0] = DATA_WIDTH'(hq);
  end
  for (genvar i = 0; i < DSTG; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else     dv[i+1] <= dv[i];
      dc[i+1] <= dc[i];
      dh[i+1] <= dh[i];
    end
  end

  // Route the half root into the chosen component; register the result.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[DSTG];
    quat.case_taken <= dc[DSTG];
    unique case (case_t'(dc[DSTG]))
      CASE_TRACE: {quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z}
                    <= {dh[DSTG], d0, d1, d2};
      CASE_X:     {quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z}
                    <= {d0, dh[DSTG], d1, d2};
      CASE_Y:     {quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z}
                    <= {d0, d1, dh[DSTG], d2};
      default:    {quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z}
                    <= {d0, d1, d2, dh[DSTG]};
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/rmq_checker.sv -----
// Port checker for the quaternion block, bound to the top level.
// Depends on rmq_pkg.
`default_nettype none
module rmq_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           busy,
  input wire logic           done,
  input wire rmq_pkg::quat_t quat
);
  import rmq_pkg::*;
  a_nobusy: assert property (@(posedge clk) busy == 1'b0) else $error("busy raised");
  a_rstdone: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
  a_trace_w: assert property (@(posedge clk) disable iff (rst)
    done && quat.case_taken == CASE_TRACE |-> !quat.quat_w[DW-1]) else $error("negative w");
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(quat)) else $error("unknown result");
endmodule
bind rotation_matrix_to_quaternion rmq_checker u_chk (
  .clk, .rst, .busy, .done, .quat
);
`default_nettype wire

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
// Testbench for rotation_matrix_to_quaternion: directed table plus random matrices,
// each result checked against an in-bench fixed-point Shepperd conversion or, for known rows, the table value.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
`default_nettype none
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FB = 14;
  localparam longint SMAX = 32767;
  localparam longint SMIN = -32768;
  localparam longint ONE = 64'sd1 << FB;
  localparam int LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mat_t mat = '0;
  logic done;
  quat_t quat;

  quat_t pending_quats[$];
  int errors = 0;
  int cycles = 0;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mat(mat), .done(done), .quat(quat)
  );

  always #2 clk = ~clk;

  // floor(sqrt(v)) by bit-pair method
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint root_fx(longint r);
    if (r <= 0) return 0;
    return longint'(int_sqrt(longint'(r) << FB));
  endfunction

  // trunc(n * 2^FB / 2q), saturated
  function automatic logic [15:0] ratio_fx(longint n, longint q);
    longint mag, quo;
    if (n == 0) return 16'd0;
    if (q == 0) return (n < 0) ? 16'h8000 : 16'h7fff;
    mag = (n < 0) ? -n : n;
    quo = (mag << FB) / (q * 2);
    if (n < 0) return (quo > SMAX + 1) ? 16'h8000 : 16'(-quo);
    return (quo > SMAX) ? 16'h7fff : 16'(quo);
  endfunction

  function automatic logic [15:0] half_fx(longint q);
    return ((q >> 1) > SMAX) ? 16'h7fff : 16'(q >> 1);
  endfunction

  function automatic quat_t matrix_to_quat(mat_t m);
    longint rx, ry, rz, ux, uy, uz, fx, fy, fz, tr, q;
    quat_t o;
    rx = m.right_x; ry = m.right_y; rz = m.right_z;
    ux = m.up_x; uy = m.up_y; uz = m.up_z;
    fx = m.fwd_x; fy = m.fwd_y; fz = m.fwd_z;
    tr = rx + uy + fz;
    if (tr > ONE) begin
      q = root_fx(tr + ONE);
      o.case_taken = CASE_TRACE;
      o.quat_w = half_fx(q);
      o.quat_x = ratio_fx(uz - fy, q);
      o.quat_y = ratio_fx(fx - rz, q);
      o.quat_z = ratio_fx(ry - ux, q);
    end else if (rx > uy && rx > fz) begin
      q = root_fx(ONE + rx - uy - fz);
      o.case_taken = CASE_X;
      o.quat_w = ratio_fx(uz - fy, q);
      o.quat_x = half_fx(q);
      o.quat_y = ratio_fx(ry + ux, q);
      o.quat_z = ratio_fx(rz + fx, q);
    end else if (uy > fz) begin
      q = root_fx(ONE + uy - rx - fz);
      o.case_taken = CASE_Y;
      o.quat_w = ratio_fx(fx - rz, q);
      o.quat_x = ratio_fx(ry + ux, q);
      o.quat_y = half_fx(q);
      o.quat_z = ratio_fx(uz + fy, q);
    end else begin
      q = root_fx(ONE + fz - rx - uy);
      o.case_taken = CASE_Z;
      o.quat_w = ratio_fx(ry - ux, q);
      o.quat_x = ratio_fx(rz + fx, q);
      o.quat_y = ratio_fx(uz + fy, q);
      o.quat_z = half_fx(q);
    end
    return o;
  endfunction

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, quat);
        errors <= errors + 1;
      end else begin
        quat_t e;
        e = pending_quats.pop_front();
        if (e.quat_w !== quat.quat_w || e.quat_x !== quat.quat_x ||
            e.quat_y !== quat.quat_y || e.quat_z !== quat.quat_z ||
            e.case_taken !== quat.case_taken) begin
          $display("%0t: expected w=%h x=%h y=%h z=%h c=%0d, got w=%h x=%h y=%h z=%h c=%0d",
                   $time, e.quat_w, e.quat_x, e.quat_y, e.quat_z, e.case_taken,
                   quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z, quat.case_taken);
          errors <= errors + 1;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("rotation_matrix_to_quaternion_tb: errors");
      $finish;
    end
  end

  // offer one matrix, hold start until the transfer
  task automatic send_matrix(mat_t m);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mat <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_quats.push_back(matrix_to_quat(m));
  endtask

  function automatic mat_t build(int a0, int a1, int a2, int a3, int a4, int a5,
                                 int a6, int a7, int a8);
    mat_t m;
    m.right_x = 16'(a0); m.right_y = 16'(a1); m.right_z = 16'(a2);
    m.up_x = 16'(a3); m.up_y = 16'(a4); m.up_z = 16'(a5);
    m.fwd_x = 16'(a6); m.fwd_y = 16'(a7); m.fwd_z = 16'(a8);
    return m;
  endfunction

  // mostly entries within +-1.0, otherwise any bit pattern
  function automatic mat_t rand_matrix();
    mat_t m;
    int sel;
    sel = $urandom_range(0, 9);
    m = mat_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (sel < 7) begin
      m.right_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.right_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.right_z = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.up_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.up_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.up_z = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.fwd_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.fwd_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      m.fwd_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    return m;
  endfunction

  typedef struct {
    mat_t m;
    logic known;
    quat_t q;
  } row_t;

  row_t rows[$];

  initial begin
    int i;
    quat_t e;
    // identity: trace branch, w = 1.0 exactly
    e = '{quat_w: 16'sd16384, quat_x: 0, quat_y: 0, quat_z: 0, case_taken: CASE_TRACE};
    rows.push_back('{build(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1, e});
    // all zero: z branch, q = 1.0, w/x/y zero
    e = '{quat_w: 0, quat_x: 0, quat_y: 0, quat_z: 16'sd8192, case_taken: CASE_Z};
    rows.push_back('{build(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, e});
    // 180 degrees about x, y, z
    rows.push_back('{build(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, e});
    rows.push_back('{build(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b0, e});
    rows.push_back('{build(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b0, e});
    // ties on the diagonal
    rows.push_back('{build(5000, 7, 9, 3, 5000, 4, 2, 1, 100), 1'b0, e});
    rows.push_back('{build(100, 7, 9, 3, 5000, 4, 2, 1, 5000), 1'b0, e});
    rows.push_back('{build(-3000, 7, 9, 3, -3000, 4, 2, 1, -3000), 1'b0, e});
    // trace exactly 1.0 stays off the trace branch
    rows.push_back('{build(16384, 5, 6, 7, 0, 8, 9, 10, 0), 1'b0, e});
    // diagonal all at -2.0: z branch with radicand 3.0
    rows.push_back('{build(-32768, 1000, -1000, 0, -32768, 50, 0, 50, -32768), 1'b0, e});
    rows.push_back('{build(-32768, 0, 0, -1, -32768, 0, 0, 0, -32768), 1'b0, e});
    // extremes of every field
    rows.push_back('{build(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
                     1'b0, e});
    rows.push_back('{build(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                           -32768), 1'b0, e});
    rows.push_back('{build(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767,
                           -32768), 1'b0, e});
    // large off-diagonals that cancel in the z-branch sums
    rows.push_back('{build(-16384, 32767, -32768, 32767, -16384, 32767, 32767, -32768,
                           -16380), 1'b0, e});
    // 90 degrees about z
    rows.push_back('{build(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), 1'b0, e});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (rows[k]) begin
      send_matrix(rows[k].m);
      if (rows[k].known) begin
        pending_quats.pop_back();
        pending_quats.push_back(rows[k].q);
      end
    end
    // random matrices
    for (i = 0; i < 1200; i++) begin
      if (i % 200 == 100) begin
        // burst with no gaps
        repeat (30) begin
          start <= 1'b1;
          mat <= rand_matrix();
          @(posedge clk);
          while (busy) @(posedge clk);
          pending_quats.push_back(matrix_to_quat(mat));
        end
      end
      send_matrix(rand_matrix());
    end
    start <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion_tb: clean");
    end else begin
      $display("rotation_matrix_to_quaternion_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/rmq_pkg.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
rtl/rmq_checker.sv
tb/rotation_matrix_to_quaternion_tb.sv
